[rtl/cau_pkg.sv]
// shared types and codes of the complex arithmetic unit
package cau_pkg;

    localparam int IO_W = 32;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } cau_mode_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DIVZ = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0]             mode;
        logic signed [IO_W-1:0] a_re;
        logic signed [IO_W-1:0] a_im;
        logic signed [IO_W-1:0] b_re;
        logic signed [IO_W-1:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [IO_W-1:0] res_re;
        logic signed [IO_W-1:0] res_im;
        logic [1:0]             status;
    } cau_out_t;

    // classified item handed from the front to the back
    typedef struct packed {
        cau_mode_t              op;
        logic                   dz;
        logic signed [IO_W-1:0] a_re;
        logic signed [IO_W-1:0] a_im;
        logic signed [IO_W-1:0] b_re;
        logic signed [IO_W-1:0] b_im;
    } cau_cmd_t;

endpackage

[rtl/cau_front.sv]
// input register that accepts items and classifies them
module cau_front
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  cau_in_t  din,
    output logic     q_push,
    input  logic     q_full,
    output cau_cmd_t cmd
);

    localparam int EW = (DATA_WIDTH > IO_W) ? DATA_WIDTH : IO_W;

    logic     f_v_reg;
    logic     f_v_next;
    cau_cmd_t cmd_reg;
    cau_cmd_t cmd_next;
    logic     accept;
    logic signed [EW-1:0] br_ext;
    logic signed [EW-1:0] bi_ext;

    assign full   = f_v_reg && q_full;
    assign accept = push && !full;
    assign q_push = f_v_reg && !q_full;
    assign cmd    = cmd_reg;

    assign br_ext = EW'(din.b_re);
    assign bi_ext = EW'(din.b_im);

    always_comb
    begin
        cmd_next      = cmd_reg;
        cmd_next.op   = cau_mode_t'(din.mode);
        // divisor is zero once wrapped to the datapath width
        cmd_next.dz   = (br_ext[DATA_WIDTH-1:0] == '0) && (bi_ext[DATA_WIDTH-1:0] == '0);
        cmd_next.a_re = din.a_re;
        cmd_next.a_im = din.a_im;
        cmd_next.b_re = din.b_re;
        cmd_next.b_im = din.b_im;
        if (accept)
        begin
            f_v_next = 1'b1;
        end
        else if (q_push)
        begin
            f_v_next = 1'b0;
        end
        else
        begin
            f_v_next = f_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else
        begin
            f_v_reg <= f_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

`ifndef SYNTH
    a_full_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> f_v_reg)
        else $error("front full without a held item");
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> f_v_reg)
        else $error("accepted item not held");
`endif

endmodule

[rtl/cau_fifo.sv]
// short queue between the front and the back
module cau_fifo
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  cau_cmd_t wdata,
    input  logic     pop,
    output logic     empty,
    output cau_cmd_t rdata
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    cau_cmd_t      mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [AW:0]   cnt_reg;
    logic [AW:0]   cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[rtl/cau_back.sv]
// execution pipeline: products, sums, pipelined divider, saturation
module cau_back
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    output logic     q_pop,
    input  cau_cmd_t cmd,
    output logic     empty,
    input  logic     pop,
    output cau_out_t dout
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int EW = (DW > IO_W) ? DW : IO_W;
    localparam int PW = 2 * DW;
    localparam int TW = PW + 1;
    localparam int W  = 3 * DW + FB + 1;

    localparam logic signed [TW-1:0] SMAX = {{(TW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [TW-1:0] SMIN = {{(TW-DW+1){1'b1}}, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic          v;
        logic          div;
        logic          dz;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [W-1:0]  rem_re;
        logic [W-1:0]  rem_im;
        logic [PW-1:0] den;
        logic [DW-1:0] q_re;
        logic [DW-1:0] q_im;
        cau_out_t      fin;
    } dstage_t;

    function automatic logic signed [DW-1:0] wrap(input logic signed [IO_W-1:0] x);
        logic signed [EW-1:0] e;
        e = EW'(x);
        return e[DW-1:0];
    endfunction

    function automatic logic signed [IO_W-1:0] widen(input logic signed [DW-1:0] x);
        logic signed [EW-1:0] e;
        e = EW'(x);
        return e[IO_W-1:0];
    endfunction

    // saturate to the datapath width, msb of the result flags saturation
    function automatic logic [DW:0] sat(input logic signed [TW-1:0] x);
        logic [DW:0] r;
        if (x > SMAX)
        begin
            r = {1'b1, DMAX};
        end
        else if (x < SMIN)
        begin
            r = {1'b1, DMIN};
        end
        else
        begin
            r = {1'b0, x[DW-1:0]};
        end
        return r;
    endfunction

    // final magnitude to signed value with saturation, msb flags saturation
    function automatic logic [DW:0] fix(input logic neg, input logic ovf,
                                        input logic [DW-1:0] q);
        logic big;
        logic [DW:0] r;
        big = ovf || (neg ? (q[DW-1] && (|q[DW-2:0])) : q[DW-1]);
        if (big)
        begin
            r = {1'b1, (neg ? DMIN : DMAX)};
        end
        else
        begin
            r = {1'b0, (neg ? (DW)'(-q) : q)};
        end
        return r;
    endfunction

    logic adv;

    // stage 1: products and plain sums
    logic                 v1_reg, v1_next;
    cau_mode_t            op1_reg;
    logic                 dz1_reg;
    logic signed [PW-1:0] prr1_reg, pii1_reg, pir1_reg, pri1_reg, sqr1_reg, sqi1_reg;
    logic signed [DW:0]   sre1_reg, sim1_reg;
    logic signed [DW-1:0] ar, ai, br, bi;

    // stage 2: combined products, scaled numerators
    logic                 v2_reg;
    dstage_t              s2_reg, s2_next;

    // divider chain, entry 0 checks quotient range, then one stage per bit
    dstage_t              dst_reg  [DW+1];
    dstage_t              dst_next [DW+1];

    // output register
    logic                 ov_reg;
    cau_out_t             o_reg, o_next;

    assign adv   = !ov_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !ov_reg;
    assign dout  = o_reg;

    assign ar = wrap(cmd.a_re);
    assign ai = wrap(cmd.a_im);
    assign br = wrap(cmd.b_re);
    assign bi = wrap(cmd.b_im);
    assign v1_next = !q_empty;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= cmd.op;
            dz1_reg  <= cmd.dz;
            prr1_reg <= PW'(ar) * PW'(br);
            pii1_reg <= PW'(ai) * PW'(bi);
            pir1_reg <= PW'(ai) * PW'(br);
            pri1_reg <= PW'(ar) * PW'(bi);
            sqr1_reg <= PW'(br) * PW'(br);
            sqi1_reg <= PW'(bi) * PW'(bi);
            if (cmd.op == MODE_SUB)
            begin
                sre1_reg <= (DW+1)'(ar) - (DW+1)'(br);
                sim1_reg <= (DW+1)'(ai) - (DW+1)'(bi);
            end
            else
            begin
                sre1_reg <= (DW+1)'(ar) + (DW+1)'(br);
                sim1_reg <= (DW+1)'(ai) + (DW+1)'(bi);
            end
        end
    end

    always_comb
    begin
        logic signed [TW-1:0] t_re;
        logic signed [TW-1:0] t_im;
        logic [DW:0]          r_re;
        logic [DW:0]          r_im;
        logic [TW-1:0]        m_re;
        logic [TW-1:0]        m_im;
        s2_next     = s2_reg;
        s2_next.v   = v1_reg;
        s2_next.div = (op1_reg == MODE_DIV);
        s2_next.dz  = dz1_reg;
        unique case (op1_reg)
            MODE_ADD, MODE_SUB:
            begin
                t_re = TW'(sre1_reg);
                t_im = TW'(sim1_reg);
            end
            MODE_MUL:
            begin
                t_re = (TW'(prr1_reg) - TW'(pii1_reg)) >>> FB;
                t_im = (TW'(pir1_reg) + TW'(pri1_reg)) >>> FB;
            end
            default:
            begin
                t_re = TW'(prr1_reg) + TW'(pii1_reg);
                t_im = TW'(pir1_reg) - TW'(pri1_reg);
            end
        endcase
        r_re = sat(t_re);
        r_im = sat(t_im);
        s2_next.fin.res_re = widen(r_re[DW-1:0]);
        s2_next.fin.res_im = widen(r_im[DW-1:0]);
        s2_next.fin.status = (r_re[DW] || r_im[DW]) ? STAT_SAT : STAT_OK;
        // divide operands: sign and magnitude of the conjugate products
        s2_next.neg_re = t_re[TW-1];
        s2_next.neg_im = t_im[TW-1];
        m_re = t_re[TW-1] ? TW'(-t_re) : TW'(t_re);
        m_im = t_im[TW-1] ? TW'(-t_im) : TW'(t_im);
        s2_next.rem_re = W'(m_re) << FB;
        s2_next.rem_im = W'(m_im) << FB;
        s2_next.den    = PW'($unsigned(sqr1_reg)) + PW'($unsigned(sqi1_reg));
        s2_next.ovf_re = 1'b0;
        s2_next.ovf_im = 1'b0;
        s2_next.q_re   = '0;
        s2_next.q_im   = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s2_next;
        end
    end

    always_comb
    begin
        logic [W-1:0] lim;
        lim              = W'(s2_reg.den) << DW;
        dst_next[0]        = s2_reg;
        dst_next[0].v      = v2_reg;
        dst_next[0].ovf_re = (s2_reg.rem_re >= lim);
        dst_next[0].ovf_im = (s2_reg.rem_im >= lim);
    end

    for (genvar j = 1; j <= DW; j++)
    begin : g_div
        localparam int K = DW - j;
        always_comb
        begin
            logic [W-1:0] dsh;
            dsh         = W'(dst_reg[j-1].den) << K;
            dst_next[j] = dst_reg[j-1];
            if (dst_reg[j-1].rem_re >= dsh)
            begin
                dst_next[j].rem_re  = dst_reg[j-1].rem_re - dsh;
                dst_next[j].q_re[K] = 1'b1;
            end
            if (dst_reg[j-1].rem_im >= dsh)
            begin
                dst_next[j].rem_im  = dst_reg[j-1].rem_im - dsh;
                dst_next[j].q_im[K] = 1'b1;
            end
        end
    end

    for (genvar j = 0; j <= DW; j++)
    begin : g_dreg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dst_reg[j] <= '0;
            end
            else if (adv)
            begin
                dst_reg[j] <= dst_next[j];
            end
        end
    end

    always_comb
    begin
        logic [DW:0] f_re;
        logic [DW:0] f_im;
        f_re   = fix(dst_reg[DW].neg_re, dst_reg[DW].ovf_re, dst_reg[DW].q_re);
        f_im   = fix(dst_reg[DW].neg_im, dst_reg[DW].ovf_im, dst_reg[DW].q_im);
        o_next = dst_reg[DW].fin;
        if (dst_reg[DW].div)
        begin
            if (dst_reg[DW].dz)
            begin
                o_next.res_re = '0;
                o_next.res_im = '0;
                o_next.status = STAT_DIVZ;
            end
            else
            begin
                o_next.res_re = widen(f_re[DW-1:0]);
                o_next.res_im = widen(f_im[DW-1:0]);
                o_next.status = (f_re[DW] || f_im[DW]) ? STAT_SAT : STAT_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= s2_next.v;
            ov_reg <= dst_reg[DW].v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg <= o_next;
        end
    end

`ifndef SYNTH
    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_reg.status == STAT_DIVZ) |-> (o_reg.res_re == '0 && o_reg.res_im == '0))
        else $error("divide by zero with nonzero result");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !pop) |=> (ov_reg && $stable(o_reg)))
        else $error("pending result lost while stalled");
`endif

endmodule

[rtl/complex_arithmetic_unit.sv]
// Complex add, subtract, multiply and divide on signed fixed-point operands
// (DATA_WIDTH bits, FRAC_BITS fractional). One item per clock is accepted
// while the queue has room and one result per clock is delivered when pop
// keeps up. An accepted item loads the input register, then passes the queue,
// a multiply stage, a combine stage, a range check, one restoring-division
// stage per quotient bit and the output register. All operations take the
// same path, so results leave in order. Quotients truncate toward zero,
// multiply results round toward minus infinity, out-of-range parts saturate
// with status 2, a zero divisor gives zero with status 1.
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  cau_in_t  din,
    output logic     empty,
    input  logic     pop,
    output cau_out_t dout
);

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    cau_cmd_t f_cmd;
    cau_cmd_t q_cmd;

    cau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .din    (din),
        .q_push (q_push),
        .q_full (q_full),
        .cmd    (f_cmd)
    );

    cau_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .full  (q_full),
        .wdata (f_cmd),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_cmd)
    );

    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .cmd     (q_cmd),
        .empty   (empty),
        .pop     (pop),
        .dout    (dout)
    );

endmodule

[dv/cau_checker.sv]
// result predictor and scoreboard for the complex arithmetic unit
module cau_checker
    import cau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  cau_in_t  din,
    input  logic     empty,
    input  logic     pop,
    input  cau_out_t dout,
    output int       errors,
    output int       pending
);

    cau_out_t expected_q[$];

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647)
        begin
            ovf = 1'b1;
            return 32'h7fff_ffff;
        end
        if (v < -128'sd2147483648)
        begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic cau_out_t complex_result(input cau_in_t it);
        logic signed [127:0] ar, ai, br, bi, den, re, im;
        logic ovf;
        cau_out_t r;
        ar = $signed(it.a_re);
        ai = $signed(it.a_im);
        br = $signed(it.b_re);
        bi = $signed(it.b_im);
        ovf = 1'b0;
        case (cau_mode_t'(it.mode))
            MODE_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL:
            begin
                // arithmetic shift rounds toward minus infinity
                re = (ar * br - ai * bi) >>> 16;
                im = (ai * br + ar * bi) >>> 16;
            end
            default:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                begin
                    r.res_re = '0;
                    r.res_im = '0;
                    r.status = STAT_DIVZ;
                    return r;
                end
                // signed division truncates toward zero
                re = ((ar * br + ai * bi) <<< 16) / den;
                im = ((ai * br - ar * bi) <<< 16) / den;
            end
        endcase
        r.res_re = clamp32(re, ovf);
        r.res_im = clamp32(im, ovf);
        r.status = ovf ? STAT_SAT : STAT_OK;
        return r;
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        cau_out_t want;
        if (rst_n)
        begin
            if (push && !full)
                expected_q.push_back(complex_result(din));
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result re=%h im=%h status=%0d",
                             $time, dout.res_re, dout.res_im, dout.status);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (dout.res_re !== want.res_re || dout.res_im !== want.res_im
                        || dout.status !== want.status)
                    begin
                        $display("%0t: mismatch expected re=%h im=%h status=%0d, actual re=%h im=%h status=%0d",
                                 $time, want.res_re, want.res_im, want.status,
                                 dout.res_re, dout.res_im, dout.status);
                        errors++;
                    end
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

[dv/tb_complex_arithmetic_unit.sv]
// stimulus and verdict for the complex arithmetic unit
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     push;
    logic     full;
    cau_in_t  din;
    logic     empty;
    logic     pop;
    cau_out_t dout;
    int       errors;
    int       pending;
    int       tx_idle;
    int       rx_stall;
    bit       hold_go;

    complex_arithmetic_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (din),
        .empty (empty),
        .pop   (pop),
        .dout  (dout)
    );

    cau_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .din     (din),
        .empty   (empty),
        .pop     (pop),
        .dout    (dout),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 500000);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0, 1, 2: return $urandom;
            3, 4, 5, 6: return 32'($signed($urandom_range(4194304)) - 2097152);
            7: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            8: return $urandom_range(1) ? 32'h0001_0000 : 32'hffff_0000;
            default: return $urandom_range(2) == 0 ? 32'd0 : 32'($signed($urandom_range(6)) - 3);
        endcase
    endfunction

    function automatic cau_in_t rand_item();
        cau_in_t it;
        it.mode = 2'($urandom_range(3));
        it.a_re = pick_operand();
        it.a_im = pick_operand();
        it.b_re = pick_operand();
        it.b_im = pick_operand();
        if ($urandom_range(29) == 0)
        begin
            it.b_re = '0;
            it.b_im = '0;
        end
        return it;
    endfunction

    function automatic cau_in_t make_item(input cau_mode_t m, input logic [31:0] ar,
                                          input logic [31:0] ai, input logic [31:0] br,
                                          input logic [31:0] bi);
        cau_in_t it;
        it.mode = m;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        return it;
    endfunction

    task automatic send_item(input cau_in_t it);
        if (tx_idle > 0)
        begin
            while ($urandom_range(99) < tx_idle)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push <= 1'b1;
        din <= it;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic drain_inputs();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                pop <= 1'b0;
                repeat (300) @(posedge clk);
            end
            pop <= ($urandom_range(99) < rx_stall) ? 1'b0 : 1'b1;
        end
    end

    initial
    begin
        push = 1'b0;
        din = '0;
        rst_n = 1'b0;
        tx_idle = 0;
        rx_stall = 0;
        hold_go = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(make_item(MODE_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
        send_item(make_item(MODE_ADD, 32'h0001_8000, 32'hffff_0000, 32'h0000_0001, 32'h0000_0000));
        send_item(make_item(MODE_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff));
        send_item(make_item(MODE_SUB, 32'h0003_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000));
        send_item(make_item(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(make_item(MODE_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000));
        send_item(make_item(MODE_MUL, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000));
        send_item(make_item(MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_item(make_item(MODE_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(MODE_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(MODE_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000));
        send_item(make_item(MODE_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000));
        send_item(make_item(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(make_item(MODE_DIV, 32'hffff_ffff, 32'h0000_0001, 32'h0003_0000, 32'hfffd_0000));
        send_item(make_item(MODE_DIV, 32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        send_item(make_item(MODE_ADD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(MODE_SUB, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle = 0;
                    rx_stall = 0;
                end
                1:
                begin
                    tx_idle = 45;
                    rx_stall = 0;
                end
                2:
                begin
                    tx_idle = 0;
                    rx_stall = 45;
                    hold_go = 1'b1;
                end
                default:
                begin
                    tx_idle = 11;
                    rx_stall = 11;
                end
            endcase
            for (int n = 0; n < 335; n++)
                send_item(rand_item());
            // pause the sender until every item has come back
            if (phase == 1)
                drain_inputs();
        end

        drain_inputs();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
